// ===== rtl/sfr_pkg.sv =====
// Shared constants and types for the serial frame receiver with sum check.
// Used by the channel interfaces and by the top level; no dependencies.
package sfr_pkg;

	// Payload widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 3;
	localparam int unsigned NUM_FB = 3;

	// Framing codes.
	localparam logic [BYTE_W-1:0] START_BYTE = 8'hEF;
	localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFE;

	// Write position reached by an overlong frame.
	localparam logic [POS_W-1:0] ABORT_POS = 3'd5;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== rtl/sfr_if.sv =====
// Valid/ready channel interfaces for received bytes and for frame results.
// Depends on sfr_pkg for payload widths.
interface sfr_byte_if;
	logic           valid;
	logic           ready;
	sfr_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic           valid;
	logic           ready;
	logic           frame_ok;
	sfr_pkg::byte_t function_code;
	sfr_pkg::byte_t data_value;
	sfr_pkg::byte_t check_value;

	modport source (output valid, output frame_ok, output function_code,
		output data_value, output check_value, input ready);
	modport sink (input valid, input frame_ok, input function_code,
		input data_value, input check_value, output ready);
endinterface

// ===== rtl/serial_frame_receiver_sum_check.sv =====
// Top level of the serial frame receiver with sum check.
// Depends on sfr_pkg and on the interfaces in sfr_if.sv.
//
// Usage:
//   Bytes from a serial receiver arrive on the rx channel, one per transfer.
//   A 0xEF byte starts (or restarts) a frame; the following bytes are kept at
//   positions 1..3, a 0xFE in the fourth position still ends the frame, and
//   any other fourth byte aborts the frame without a result. A 0xFE byte ends
//   the frame and, at positions 1..3, is first stored in place. On the frame
//   channel one result transfer follows each completed frame: frame_ok is set
//   when byte 1 plus byte 2, at full width, equals byte 3, and the three bytes
//   are shown on pass and zero on fail. Bytes outside a frame are dropped.
//
//   Throughput is one byte per cycle. A byte is captured in an input
//   register and from there updates the frame state and, on a 0xFE that
//   ends a frame, loads the result register that drives the frame channel.
//   The result register is the only limit: while a result waits and the
//   receiver holds ready low, a byte that would produce another result waits
//   in the input register and rx ready drops. Bytes that produce no result
//   keep moving during such a stall. Reset clears the frame state, the input
//   valid and the result valid.
module serial_frame_receiver_sum_check (
	input  logic              clk,
	input  logic              arst_n,
	sfr_byte_if.sink          rx,
	sfr_result_if.source      frame
);

	// Input register.
	logic           valid_s1;
	sfr_pkg::byte_t byte_s1;

	// Frame state.
	logic                       in_frame_q;
	logic [sfr_pkg::POS_W-1:0]  wpos_q;
	sfr_pkg::byte_t             fb_q [sfr_pkg::NUM_FB];

	// Result register.
	logic           res_valid_q;
	logic           res_ok_q;
	sfr_pkg::byte_t res_fc_q;
	sfr_pkg::byte_t res_dv_q;
	sfr_pkg::byte_t res_cv_q;

	// Decode of the registered byte.
	logic                       is_start;
	logic                       is_end;
	logic                       gives_result;
	logic                       advance;
	logic                       out_free;
	logic [sfr_pkg::POS_W-1:0]  wpos_inc;
	sfr_pkg::byte_t             eff [sfr_pkg::NUM_FB];
	logic [sfr_pkg::BYTE_W:0]   sum;
	logic                       pass;

	assign is_start     = (byte_s1 == sfr_pkg::START_BYTE);
	assign is_end       = (byte_s1 == sfr_pkg::END_BYTE);
	assign gives_result = valid_s1 && !is_start && in_frame_q && is_end;
	assign out_free     = !res_valid_q || frame.ready;
	assign advance      = valid_s1 && (!gives_result || out_free);
	assign rx.ready     = !valid_s1 || advance;
	assign wpos_inc     = wpos_q + 1'b1;

	// Frame bytes with the current byte stored at the write position.
	always_comb begin
		for (int i = 0; i < sfr_pkg::NUM_FB; i++) begin
			eff[i] = fb_q[i];
			if (wpos_q == sfr_pkg::POS_W'(i + 1)) begin
				eff[i] = byte_s1;
			end
		end
		sum  = {1'b0, eff[0]} + {1'b0, eff[1]};
		pass = (sum == {1'b0, eff[2]});
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Frame state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			wpos_q     <= '0;
			for (int i = 0; i < sfr_pkg::NUM_FB; i++) begin
				fb_q[i] <= '0;
			end
		end else if (advance) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				wpos_q     <= sfr_pkg::POS_W'(1);
				for (int i = 0; i < sfr_pkg::NUM_FB; i++) begin
					fb_q[i] <= '0;
				end
			end else if (in_frame_q) begin
				if (is_end || wpos_inc >= sfr_pkg::ABORT_POS) begin
					in_frame_q <= 1'b0;
					wpos_q     <= '0;
					for (int i = 0; i < sfr_pkg::NUM_FB; i++) begin
						fb_q[i] <= '0;
					end
				end else begin
					wpos_q <= wpos_inc;
					for (int i = 0; i < sfr_pkg::NUM_FB; i++) begin
						fb_q[i] <= eff[i];
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && gives_result) begin
			res_valid_q <= 1'b1;
		end else if (frame.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gives_result) begin
			res_ok_q <= pass;
			res_fc_q <= pass ? eff[0] : '0;
			res_dv_q <= pass ? eff[1] : '0;
			res_cv_q <= pass ? eff[2] : '0;
		end
	end

	assign frame.valid         = res_valid_q;
	assign frame.frame_ok      = res_ok_q;
	assign frame.function_code = res_fc_q;
	assign frame.data_value    = res_dv_q;
	assign frame.check_value   = res_cv_q;

	// Idle state keeps the position at zero and the frame bytes clear.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (wpos_q == '0 && fb_q[0] == '0 && fb_q[1] == '0
			&& fb_q[2] == '0))
		else $error("idle frame state not cleared");

	// The write position never reaches the abort position.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q < sfr_pkg::ABORT_POS)
		else $error("write position out of range");

	// A failed frame shows zero bytes.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && !frame.frame_ok) |-> (frame.function_code == '0
			&& frame.data_value == '0 && frame.check_value == '0))
		else $error("failed frame with nonzero bytes");

	// A passed frame satisfies the sum check.
	a_pass_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.frame_ok) |->
			(({1'b0, frame.function_code} + {1'b0, frame.data_value})
				== {1'b0, frame.check_value}))
		else $error("passed frame fails sum check");

	// A result that finishes while the output is blocked holds the input.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(gives_result && !out_free) |-> !rx.ready)
		else $error("input taken while result is blocked");

endmodule

// ===== tb/sv/sfr_frame_result_check.sv =====
`timescale 1ns / 1ps
// Scoreboard for the serial frame receiver: follows the frame state from accepted bytes,
// predicts each frame result and compares it with the result transfers of the block.
// Depends on sfr_pkg and on the channel interfaces in sfr_if.sv.
module sfr_frame_result_check (
	input  logic        clk,
	input  logic        arst_n,
	sfr_byte_if         rx,
	sfr_result_if       frame,
	output int unsigned mismatches,
	output int unsigned awaiting
);
	import sfr_pkg::*;

	typedef struct packed {
		logic  ok;
		byte_t function_code;
		byte_t data_value;
		byte_t check_value;
	} frame_result_t;

	// Predicted frame state.
	logic          in_frame;
	logic [POS_W-1:0] wr_pos;
	byte_t         kept [NUM_FB];
	frame_result_t results_due [$];

	initial mismatches = 0;

	task automatic report(input string what, input frame_result_t want,
		input frame_result_t got);
		if (mismatches < 10) begin
			$write("%0t: frame result %s: expected ok=%0b fc=%02h dv=%02h cv=%02h",
				$time, what, want.ok, want.function_code, want.data_value,
				want.check_value);
			$display(", got ok=%0b fc=%02h dv=%02h cv=%02h",
				got.ok, got.function_code, got.data_value, got.check_value);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		frame_result_t want;
		frame_result_t got;
		logic [BYTE_W:0] total;
		if (!arst_n) begin
			in_frame = 1'b0;
			wr_pos = '0;
			kept = '{default: '0};
			results_due.delete();
			awaiting = 0;
		end else begin
			// Each accepted byte moves the predicted frame state; a terminator yields a result.
			if (rx.valid === 1'b1 && rx.ready === 1'b1) begin
				if (rx.rx_byte == START_BYTE) begin
					kept = '{default: '0};
					wr_pos = 3'd1;
					in_frame = 1'b1;
				end else if (in_frame) begin
					if (wr_pos >= 3'd1 && wr_pos <= 3'd3) begin
						kept[2'(wr_pos - 3'd1)] = rx.rx_byte;
					end
					if (rx.rx_byte == END_BYTE) begin
						// The sum is taken one bit wider, so it never wraps.
						total = {1'b0, kept[0]} + {1'b0, kept[1]};
						want = '0;
						if (total == {1'b0, kept[2]}) begin
							want = '{1'b1, kept[0], kept[1], kept[2]};
						end
						results_due.push_back(want);
						kept = '{default: '0};
						wr_pos = '0;
						in_frame = 1'b0;
					end else begin
						wr_pos = wr_pos + 3'd1;
						// An overlong frame is dropped without a result.
						if (wr_pos >= ABORT_POS) begin
							kept = '{default: '0};
							wr_pos = '0;
							in_frame = 1'b0;
						end
					end
				end
			end

			// Each result transfer is matched against the oldest prediction.
			if (frame.valid === 1'b1 && frame.ready === 1'b1) begin
				got = '{frame.frame_ok, frame.function_code, frame.data_value,
					frame.check_value};
				if (results_due.size() == 0) begin
					report("with none expected", '0, got);
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						report("mismatch", want, got);
					end
				end
			end
			awaiting = results_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for serial_frame_receiver_sum_check: drives byte streams with random gaps
// and receiver stalls, and gives the verdict from the scoreboard in sfr_frame_result_check.sv.
// Depends on sfr_pkg, sfr_if.sv and the block itself.
module tb_top;
	import sfr_pkg::*;

	localparam int unsigned STIM_BYTES   = 1950;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned DRAIN_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned payload_sent = 0;
	bit          src_steady = 1'b0;

	// Short opening stream: wrap in the sum, terminator at positions 1 and 3,
	// restart inside a frame with extremes and a fourth byte, and an overlong frame.
	byte_t opening [25] = '{
		START_BYTE, 8'h80, 8'h80, 8'h00, END_BYTE,
		START_BYTE, END_BYTE,
		START_BYTE, 8'h7F, 8'h7F, END_BYTE,
		START_BYTE, 8'h01, START_BYTE, 8'h00, 8'hFF, 8'hFF, 8'h55, END_BYTE,
		START_BYTE, 8'h11, 8'h22, 8'h33, 8'h44, END_BYTE
	};

	sfr_byte_if   rx ();
	sfr_result_if frame ();

	serial_frame_receiver_sum_check dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.frame  (frame)
	);

	sfr_frame_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.frame      (frame),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Frame content byte that neither starts nor ends a frame.
	function automatic byte_t pick_payload();
		byte_t b;
		do begin
			b = byte_t'($urandom_range(0, 255));
		end while (b == START_BYTE || b == END_BYTE);
		return b;
	endfunction

	// Offers one byte after an optional gap and returns at the falling edge after its transfer.
	task automatic send_byte(input byte_t b, input bit counted);
		int unsigned gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (rx.ready !== 1'b1);
		@(negedge clk);
		if (counted) payload_sent++;
	endtask

	// Result side: random stalls, quiet stretches and an occasional long hold-off.
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned cycle_no;
		int unsigned next_hold;
		bit quiet;
		frame.ready = 1'b0;
		stall_left = 0;
		cycle_no = 0;
		next_hold = 300;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cycle_no++;
			if (cycle_no % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
			if (cycle_no == next_hold) begin
				stall_left = LONG_HOLD;
				next_hold += $urandom_range(1500, 3000);
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				frame.ready <= 1'b0;
				stall_left--;
			end else begin
				frame.ready <= 1'b1;
			end
		end
	end

	// Ends the run when no transfer happens on either channel for too long.
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
				(frame.valid === 1'b1 && frame.ready === 1'b1)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("** serial_frame_receiver_sum_check: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int unsigned kind;
		byte_t b1;
		byte_t b2;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) begin
			send_byte(opening[i], 1'b1);
		end

		// Random frames and noise, many of them well formed with random content.
		while (payload_sent < STIM_BYTES) begin
			if ($urandom_range(0, 31) == 0) src_steady = ($urandom_range(0, 2) == 0);
			kind = $urandom_range(0, 99);
			if (kind >= 90) begin
				// Noise between frames.
				repeat ($urandom_range(1, 4)) begin
					do begin
						b1 = byte_t'($urandom_range(0, 255));
					end while (b1 == START_BYTE);
					send_byte(b1, 1'b0);
				end
			end else if (kind >= 80) begin
				// Overlong frame, aborted at the fourth position.
				send_byte(START_BYTE, 1'b1);
				repeat ($urandom_range(4, 6)) send_byte(pick_payload(), 1'b1);
				send_byte(END_BYTE, 1'b1);
			end else if (kind >= 60) begin
				// Short frame with arbitrary content, usually failing the check.
				send_byte(START_BYTE, 1'b1);
				repeat ($urandom_range(0, 4)) send_byte(pick_payload(), 1'b1);
				send_byte(END_BYTE, 1'b1);
			end else begin
				// Partial frame cut short by a new start.
				if (kind >= 50) begin
					send_byte(START_BYTE, 1'b1);
					repeat ($urandom_range(0, 3)) send_byte(pick_payload(), 1'b1);
				end
				// Frame whose check byte is the sum of the first two.
				case ($urandom_range(0, 5))
					0: b1 = 8'h00;
					1: b1 = 8'hFF;
					default: b1 = pick_payload();
				endcase
				do begin
					b2 = byte_t'($urandom_range(0, 255 - b1));
				end while (b2 == START_BYTE || b2 == END_BYTE);
				send_byte(START_BYTE, 1'b1);
				send_byte(b1, 1'b1);
				send_byte(b2, 1'b1);
				send_byte(b1 + b2, 1'b1);
				if ($urandom_range(0, 4) == 0) send_byte(pick_payload(), 1'b1);
				send_byte(END_BYTE, 1'b1);
			end
		end
		rx.valid <= 1'b0;

		while (awaiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("** serial_frame_receiver_sum_check: PASSED **");
		end else begin
			$display("** serial_frame_receiver_sum_check: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/serial_frame_receiver_sum_check.sv
tb/sv/sfr_frame_result_check.sv
tb/sv/tb_top.sv
